### src/sccr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// sector cache tag engine. No dependencies.
package sccr_pkg;

   localparam int ENTRIES  = 64;
   localparam int LANES    = 8;
   localparam int ROWS     = ENTRIES / LANES;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int LANE_W   = $clog2(LANES);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int SECTOR_W = 32;
   localparam int SLOT_W   = 6;
   localparam int MODE_W   = 2;

   localparam int RSP_FIELDS_W = 1 + SLOT_W + 1 + 1 + SECTOR_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // request kinds
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

   // tag read address source
   localparam logic [1:0] RD_SEARCH = 2'd0;
   localparam logic [1:0] RD_HAND   = 2'd1;
   localparam logic [1:0] RD_IDX    = 2'd2;

   // result kinds loaded into the output register
   localparam logic [2:0] EMIT_NONE  = 3'd0;
   localparam logic [2:0] EMIT_HIT   = 3'd1;
   localparam logic [2:0] EMIT_MISS  = 3'd2;
   localparam logic [2:0] EMIT_WB    = 3'd3;
   localparam logic [2:0] EMIT_EMPTY = 3'd4;

   typedef struct packed {
      logic       load_req;   // latch request, restart search and flush index
      logic       search;     // advance tag search by one row
      logic       sweep;      // clear chance bit under hand, step hand
      logic [1:0] rd_sel;
      logic [2:0] emit;
      logic       clear_all;  // invalidate every entry
      logic       idx_inc;
   } sccr_cmd_type;

   typedef struct packed {
      logic hit_found;
      logic search_done;
      logic hand_chance;
      logic ent_vd;       // entry under flush index is valid and dirty
      logic any_vd;
      logic more_vd;      // another valid dirty entry besides the current one
      logic out_free;
   } sccr_status_type;

endpackage

### src/sector_cache_clock_replacement.sv
// Top level of the sector cache tag engine: stream ports, controller and
// datapath. Depends on sccr_pkg, sccr_ctrl and sccr_dp.
//
// Tag and policy engine for a 64-entry fully associative sector cache with
// clock (second chance) replacement. Each request word asks to read, write
// or flush; read and write give one result word naming the slot of an
// external data store, whether it hit, whether a fill is needed and, on a
// miss that evicts a dirty entry, the old sector to write back. A flush
// gives one writeback word per dirty entry in ascending slot order, the
// final one marked with tlast (a single all-zero word with tlast if nothing
// is dirty), then invalidates every entry; mode 3 is taken and ignored.
// Tags sit in eight lane RAMs, one row of eight tags read per cycle, and
// the lookup stops at the first row with a hit or after the last row. A
// miss then sweeps the hand, clearing each chance bit it meets, until it
// finds an entry without one, which becomes the victim. The controller is
// back in idle as the result is loaded, so the next request word is taken
// in the following cycle at the earliest. A flush scans entries upward
// from slot 0 to the last dirty one, sending a writeback word for each.
// A full output register holds the controller in its emitting state. One
// request is in progress at a time; a result word waits in the output
// register without blocking acceptance of the next request word. No
// clearing pass is needed after reset.
module sector_cache_clock_replacement (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sccr_pkg::SECTOR_W-1:0]        req_tdata,   // [31:0] sector
   input  logic [sccr_pkg::MODE_W-1:0]          req_tuser,   // [1:0] mode
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] hit, [6:1] slot, [7] fill_needed, [8] writeback_needed,
   // [40:9] writeback_sector, [47:41] zero
   output logic [sccr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);
   import sccr_pkg::*;

   sccr_cmd_type    cmd;
   sccr_status_type status;

   logic                rsp_hit;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_fill;
   logic                rsp_wb;
   logic [SECTOR_W-1:0] rsp_wb_sector;

   sccr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sccr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_mode      (req_tuser),
      .req_sector    (req_tdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_hit       (rsp_hit),
      .rsp_slot      (rsp_slot),
      .rsp_fill      (rsp_fill),
      .rsp_wb        (rsp_wb),
      .rsp_wb_sector (rsp_wb_sector),
      .rsp_last      (rsp_tlast)
   );

   // fields packed from bit 0 up, zero-padded to whole bytes
   assign rsp_tdata = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}},
                       rsp_wb_sector, rsp_wb, rsp_fill, rsp_slot, rsp_hit};

endmodule

### src/sccr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sccr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sccr_dp.sv
// Datapath: tag RAM lanes, valid/dirty/chance bits, clock hand, search and
// flush counters, result register. Depends on sccr_pkg and sccr_ram.
module sccr_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sccr_pkg::MODE_W-1:0]  req_mode,
   input  logic [sccr_pkg::SECTOR_W-1:0] req_sector,
   input  sccr_pkg::sccr_cmd_type       cmd,
   output sccr_pkg::sccr_status_type    status,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [sccr_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                         rsp_fill,
   output logic                         rsp_wb,
   output logic [sccr_pkg::SECTOR_W-1:0] rsp_wb_sector,
   output logic                         rsp_last
);
   import sccr_pkg::*;

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [SECTOR_W-1:0] sector_ff, sector_in;
   logic [ROW_W-1:0]    rd_row_ff, rd_row_in;
   logic                look_ff, look_in;
   logic [ROW_W-1:0]    look_row_ff, look_row_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]    hand_ff, hand_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [ENTRIES-1:0]  dirty_ff, dirty_in;
   logic [ENTRIES-1:0]  chance_ff, chance_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                o_hit_ff, o_hit_in;
   logic [SLOT_W-1:0]   o_slot_ff, o_slot_in;
   logic                o_fill_ff, o_fill_in;
   logic                o_wb_ff, o_wb_in;
   logic [SECTOR_W-1:0] o_wbsec_ff, o_wbsec_in;
   logic                o_last_ff, o_last_in;

   logic [ROW_W-1:0]    rd_addr;
   logic [SECTOR_W-1:0] rd_q [LANES];
   logic [LANES-1:0]    match;
   logic [LANE_W-1:0]   hit_lane;
   logic [ENTRIES-1:0]  vd;
   logic                is_write;
   logic                victim_wb;
   logic                install;

   assign is_write = (mode_ff == MODE_WRITE);
   assign vd       = valid_ff & dirty_ff;
   assign install  = (cmd.emit == EMIT_MISS);

   always_comb begin
      case (cmd.rd_sel)
         RD_SEARCH: rd_addr = rd_row_ff;
         RD_HAND:   rd_addr = hand_ff[IDX_W-1:LANE_W];
         RD_IDX:    rd_addr = idx_ff[IDX_W-1:LANE_W];
         default:   rd_addr = rd_row_ff;
      endcase
   end

   // one tag RAM per lane; a row holds LANES neighbouring entries
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      sccr_ram #(
         .WIDTH (SECTOR_W),
         .DEPTH (ROWS)
      ) u_tag (
         .clock   (clock),
         .wr_en   (install && (hand_ff[LANE_W-1:0] == LANE_W'(l))),
         .wr_addr (hand_ff[IDX_W-1:LANE_W]),
         .wr_data (sector_ff),
         .rd_addr (rd_addr),
         .rd_data (rd_q[l])
      );
      assign match[l] = valid_ff[{look_row_ff, LANE_W'(l)}] && (rd_q[l] == sector_ff);
   end

   // lowest lane wins
   always_comb begin
      hit_lane = '0;
      for (int l = LANES - 1; l >= 0; l--) begin
         if (match[l]) begin
            hit_lane = LANE_W'(l);
         end
      end
   end

   assign victim_wb = valid_ff[hand_ff] && dirty_ff[hand_ff];

   assign status.hit_found   = look_ff && (|match);
   assign status.search_done = look_ff && (look_row_ff == ROW_W'(ROWS - 1));
   assign status.hand_chance = chance_ff[hand_ff];
   assign status.ent_vd      = vd[idx_ff];
   assign status.any_vd      = |vd;
   assign status.more_vd     = |(vd & ~(ENTRIES'(1) << idx_ff));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mode_in      = mode_ff;
      sector_in    = sector_ff;
      rd_row_in    = rd_row_ff;
      look_in      = look_ff;
      look_row_in  = look_row_ff;
      hit_idx_in   = hit_idx_ff;
      hand_in      = hand_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      chance_in    = chance_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_hit_in     = o_hit_ff;
      o_slot_in    = o_slot_ff;
      o_fill_in    = o_fill_ff;
      o_wb_in      = o_wb_ff;
      o_wbsec_in   = o_wbsec_ff;
      o_last_in    = o_last_ff;

      if (cmd.load_req) begin
         mode_in   = req_mode;
         sector_in = req_sector;
         rd_row_in = '0;
         look_in   = 1'b0;
         idx_in    = '0;
      end

      if (cmd.search) begin
         rd_row_in   = rd_row_ff + 1'b1;
         look_in     = 1'b1;
         look_row_in = rd_row_ff;
         if (status.hit_found) begin
            hit_idx_in = {look_row_ff, hit_lane};
         end
      end

      if (cmd.sweep) begin
         chance_in[hand_ff] = 1'b0;
         hand_in = (hand_ff == IDX_W'(ENTRIES - 1)) ? '0 : hand_ff + 1'b1;
      end

      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end

      case (cmd.emit)
         EMIT_HIT: begin
            rsp_valid_in = 1'b1;
            o_hit_in     = 1'b1;
            o_slot_in    = SLOT_W'(hit_idx_ff);
            o_fill_in    = 1'b0;
            o_wb_in      = 1'b0;
            o_wbsec_in   = '0;
            o_last_in    = 1'b1;
            chance_in[hit_idx_ff] = 1'b1;
            if (is_write) begin
               dirty_in[hit_idx_ff] = 1'b1;
            end
         end
         EMIT_MISS: begin
            rsp_valid_in = 1'b1;
            o_hit_in     = 1'b0;
            o_slot_in    = SLOT_W'(hand_ff);
            o_fill_in    = 1'b1;
            o_wb_in      = victim_wb;
            o_wbsec_in   = victim_wb ? rd_q[hand_ff[LANE_W-1:0]] : '0;
            o_last_in    = 1'b1;
            valid_in[hand_ff]  = 1'b1;
            chance_in[hand_ff] = 1'b1;
            dirty_in[hand_ff]  = is_write;
         end
         EMIT_WB: begin
            rsp_valid_in = 1'b1;
            o_hit_in     = 1'b0;
            o_slot_in    = SLOT_W'(idx_ff);
            o_fill_in    = 1'b0;
            o_wb_in      = 1'b1;
            o_wbsec_in   = rd_q[idx_ff[LANE_W-1:0]];
            o_last_in    = !status.more_vd;
            dirty_in[idx_ff] = 1'b0;
         end
         EMIT_EMPTY: begin
            rsp_valid_in = 1'b1;
            o_hit_in     = 1'b0;
            o_slot_in    = '0;
            o_fill_in    = 1'b0;
            o_wb_in      = 1'b0;
            o_wbsec_in   = '0;
            o_last_in    = 1'b1;
         end
         default: begin
         end
      endcase

      if (cmd.clear_all) begin
         valid_in  = '0;
         dirty_in  = '0;
         chance_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff      <= 1'b0;
         hand_ff      <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         chance_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         look_ff      <= look_in;
         hand_ff      <= hand_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         chance_ff    <= chance_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      sector_ff   <= sector_in;
      rd_row_ff   <= rd_row_in;
      look_row_ff <= look_row_in;
      hit_idx_ff  <= hit_idx_in;
      idx_ff      <= idx_in;
      o_hit_ff    <= o_hit_in;
      o_slot_ff   <= o_slot_in;
      o_fill_ff   <= o_fill_in;
      o_wb_ff     <= o_wb_in;
      o_wbsec_ff  <= o_wbsec_in;
      o_last_ff   <= o_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = o_hit_ff;
   assign rsp_slot      = o_slot_ff;
   assign rsp_fill      = o_fill_ff;
   assign rsp_wb        = o_wb_ff;
   assign rsp_wb_sector = o_wbsec_ff;
   assign rsp_last      = o_last_ff;

endmodule

### src/sccr_ctrl.sv
// Controller state machine: sequences search, clock sweep, install and
// flush over the datapath. Depends on sccr_pkg.
module sccr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [sccr_pkg::MODE_W-1:0] req_mode,
   output logic                        req_ready,
   input  sccr_pkg::sccr_status_type   status,
   output sccr_pkg::sccr_cmd_type      cmd
);
   import sccr_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SEARCH = 4'd1;
   localparam logic [3:0] ST_HIT    = 4'd2;
   localparam logic [3:0] ST_SWEEP  = 4'd3;
   localparam logic [3:0] ST_VICTIM = 4'd4;
   localparam logic [3:0] ST_FSTART = 4'd5;
   localparam logic [3:0] ST_FSCAN  = 4'd6;
   localparam logic [3:0] ST_FWB    = 4'd7;
   localparam logic [3:0] ST_FEMPTY = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd.load_req  = 1'b0;
      cmd.search    = 1'b0;
      cmd.sweep     = 1'b0;
      cmd.rd_sel    = RD_SEARCH;
      cmd.emit      = EMIT_NONE;
      cmd.clear_all = 1'b0;
      cmd.idx_inc   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_mode)
                  MODE_READ, MODE_WRITE: state_in = ST_SEARCH;
                  MODE_FLUSH:            state_in = ST_FSTART;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.hit_found) begin
               state_in = ST_HIT;
            end else if (status.search_done) begin
               state_in = ST_SWEEP;
            end
         end
         ST_HIT: begin
            if (status.out_free) begin
               cmd.emit = EMIT_HIT;
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cmd.rd_sel = RD_HAND;
            if (status.hand_chance) begin
               cmd.sweep = 1'b1;
            end else begin
               state_in = ST_VICTIM;
            end
         end
         ST_VICTIM: begin
            cmd.rd_sel = RD_HAND;
            if (status.out_free) begin
               cmd.emit = EMIT_MISS;
               state_in = ST_IDLE;
            end
         end
         ST_FSTART: begin
            state_in = status.any_vd ? ST_FSCAN : ST_FEMPTY;
         end
         ST_FSCAN: begin
            cmd.rd_sel = RD_IDX;
            if (status.ent_vd) begin
               state_in = ST_FWB;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_FWB: begin
            cmd.rd_sel = RD_IDX;
            if (status.out_free) begin
               cmd.emit = EMIT_WB;
               if (status.more_vd) begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_FSCAN;
               end else begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_FEMPTY: begin
            if (status.out_free) begin
               cmd.emit      = EMIT_EMPTY;
               cmd.clear_all = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
